// ===== hdl/mqsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsp_pkg
// Shared constants and helpers for the motion queue speed planner.
// ----------------------------------------------------------------------------
package mqsp_pkg;

  localparam int QDEPTH = 16;
  localparam int PTR_W  = 4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_MINSP = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;
  localparam logic [1:0] REG_JEXP  = 2'd3;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) r = 32'h7FFF_FFFF;
    else if (v[33] && (v[32:31] != 2'b11)) r = 32'h8000_0000;
    else r = v[31:0];
    sat34 = r;
  endfunction

endpackage

// ===== hdl/mqsp_div.sv =====
// ----------------------------------------------------------------------------
// mqsp_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mqsp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import mqsp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, dvd_r[63]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? 32'(rem_sh - {1'b0, dsr_r}) : rem_sh[31:0];
        dvd_r <= {dvd_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ===== hdl/mqsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// mqsp_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mqsp_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import mqsp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [63:0] trial;
  logic        ge;

  assign trial = r_r + bit_r;
  assign ge    = v_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= radicand;
        r_r    <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        if (ge) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

// ===== hdl/motion_queue_speed_planner.sv =====
// ----------------------------------------------------------------------------
// motion_queue_speed_planner
// Move queue with trapezoidal speed ramp and junction exit rates.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | operation, delta_x/y/z, feed
// out_    | output    | out_valid/out_ready| status, pos_x/y/z, speed, moving,
//         |           |                    | queue_count
// cfg     | input     | psel/penable       | APB registers at 0x0..0xC
//
// One request at a time; the shared divider and root unit set how long a push
// or a tick takes.
// in_ready is high only while idle; a result waits in the output register.
// rst_n is synchronous; queue entries have no reset, valid bits mark written entries.
// ----------------------------------------------------------------------------
module motion_queue_speed_planner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_delta_x,
  input  logic [31:0] in_delta_y,
  input  logic [31:0] in_delta_z,
  input  logic [31:0] in_feed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_speed,
  output logic        out_moving,
  output logic [3:0]  out_queue_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mqsp_pkg::*;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_P_SQX  = 6'd1;
  localparam logic [5:0] S_P_SQY  = 6'd2;
  localparam logic [5:0] S_P_SQZ  = 6'd3;
  localparam logic [5:0] S_P_SUM  = 6'd4;
  localparam logic [5:0] S_P_RTW  = 6'd5;
  localparam logic [5:0] S_P_DIV  = 6'd6;
  localparam logic [5:0] S_P_DIVW = 6'd7;
  localparam logic [5:0] S_P_JX   = 6'd8;
  localparam logic [5:0] S_P_JY   = 6'd9;
  localparam logic [5:0] S_P_JS   = 6'd10;
  localparam logic [5:0] S_P_JSW  = 6'd11;
  localparam logic [5:0] S_P_POW  = 6'd12;
  localparam logic [5:0] S_P_POW2 = 6'd13;
  localparam logic [5:0] S_P_MEAN = 6'd14;
  localparam logic [5:0] S_P_EXW  = 6'd15;
  localparam logic [5:0] S_T_RD   = 6'd16;
  localparam logic [5:0] S_T_IM   = 6'd17;
  localparam logic [5:0] S_T_ID   = 6'd18;
  localparam logic [5:0] S_T_IW   = 6'd19;
  localparam logic [5:0] S_T_MAIN = 6'd20;
  localparam logic [5:0] S_T_FLR  = 6'd21;
  localparam logic [5:0] S_T_POP  = 6'd22;
  localparam logic [5:0] S_T_PRD  = 6'd23;
  localparam logic [5:0] S_T_PRD2 = 6'd24;
  localparam logic [5:0] S_C_MA   = 6'd25;
  localparam logic [5:0] S_C_MB   = 6'd26;
  localparam logic [5:0] S_C_DIV  = 6'd27;
  localparam logic [5:0] S_C_DIVW = 6'd28;
  localparam logic [5:0] S_FIN    = 6'd29;
  localparam logic [5:0] S_OUT    = 6'd30;

  // configuration
  logic [31:0] accel_r, minsp_r, scale_r;
  logic [3:0]  jexp_r;

  // queue storage
  logic [31:0] q_dx_mem   [QDEPTH];
  logic [31:0] q_dy_mem   [QDEPTH];
  logic [31:0] q_dz_mem   [QDEPTH];
  logic [31:0] q_len_mem  [QDEPTH];
  logic [31:0] q_base_mem [QDEPTH];
  logic [31:0] q_exit_mem [QDEPTH];
  logic [QDEPTH-1:0] q_vld_r;
  logic [PTR_W-1:0]  rd_addr_r;
  logic [31:0] rd_dx_r, rd_dy_r, rd_dz_r, rd_len_r, rd_base_r, rd_exit_r;
  logic        rd_vld_r;

  // control state
  logic [5:0]       state_r;
  logic [PTR_W-1:0] wp_r, rp_r, slot_r;
  logic             active_r, exit_r, ck_ret_r, isel_r;
  logic [31:0]      travel_r, speed_r, target_r, ckpt_r;
  logic [31:0]      tool_x_r, tool_y_r, tool_z_r;
  logic [1:0]       status_r, dsel_r;
  logic [3:0]       pcnt_r;

  // working registers
  logic [31:0] dx_r, dy_r, dz_r, feed_r, len_new_r, base_new_r, px_r, py_r;
  logic [31:0] uxp_r, uyp_r, uxn_r, uyn_r;
  logic [30:0] f_r, p_r;
  logic [63:0] acc_r, prod_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic [31:0] o_px_r, o_py_r, o_pz_r, o_speed_r;
  logic        o_moving_r;
  logic [3:0]  o_count_r;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic        div_start, div_done, sq_start, sq_done;
  logic [63:0] div_dvd, div_q, sq_in;
  logic [31:0] div_dsr, sq_root;

  logic        ent_we, ex_we;
  logic [PTR_W-1:0] ex_addr;
  logic [31:0] ex_data;
  logic [PTR_W-1:0] prev_ptr;
  logic        full;

  logic [32:0] exd, eyd;
  logic [31:0] exm, eym, ck_lo, ck_d, mean, dmag, off, sp_fl, accel_eff;
  logic [31:0] ramp_diff, tgt;
  logic        trig;
  logic [32:0] base_sum, trav_sum;
  logic [33:0] ipos;

  assign prev_ptr = wp_r - 1'b1;
  assign full     = (wp_r + 1'b1) == rp_r;

  mqsp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  mqsp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  // APB
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_ACCEL: prdata = accel_r;
      REG_MINSP: prdata = minsp_r;
      REG_SCALE: prdata = scale_r;
      REG_JEXP:  prdata = {28'd0, jexp_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 32'd66;
      minsp_r <= 32'd7;
      scale_r <= 32'd71583;
      jexp_r  <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ACCEL: accel_r <= pwdata;
        REG_MINSP: minsp_r <= pwdata;
        REG_SCALE: scale_r <= pwdata;
        REG_JEXP:  jexp_r  <= pwdata[3:0];
        default:   accel_r <= accel_r;
      endcase
    end
  end

  // datapath helpers
  assign exd       = {uxp_r[31], uxp_r} - {uxn_r[31], uxn_r};
  assign eyd       = {uyp_r[31], uyp_r} - {uyn_r[31], uyn_r};
  assign exm       = exd[32] ? 32'(33'd0 - exd) : exd[31:0];
  assign eym       = eyd[32] ? 32'(33'd0 - eyd) : eyd[31:0];
  assign ck_lo     = (speed_r < rd_exit_r) ? speed_r : rd_exit_r;
  assign ck_d      = (speed_r < rd_exit_r) ? (rd_exit_r - speed_r) : (speed_r - rd_exit_r);
  assign base_sum  = {1'b0, base_new_r} + {1'b0, rd_base_r};
  assign mean      = base_sum[32:1];
  assign dmag      = mag32(isel_r ? rd_dy_r : rd_dx_r);
  assign off       = div_q[31:0];
  assign accel_eff = (accel_r == 32'd0) ? 32'd1 : accel_r;
  assign sp_fl     = (speed_r < minsp_r) ? minsp_r : speed_r;
  assign trav_sum  = {1'b0, travel_r} + {1'b0, sp_fl};
  assign trig      = !exit_r && ((travel_r > ckpt_r) || (ckpt_r == 32'd0));
  assign tgt       = trig ? rd_exit_r : target_r;
  assign ramp_diff = (tgt > speed_r) ? (tgt - speed_r) : (speed_r - tgt);
  assign ipos      = (isel_r ? rd_dy_r[31] : rd_dx_r[31])
                   ? {{2{(isel_r ? py_r[31] : px_r[31])}}, (isel_r ? py_r : px_r)}
                     - {2'b00, off}
                   : {{2{(isel_r ? py_r[31] : px_r[31])}}, (isel_r ? py_r : px_r)}
                     + {2'b00, off};

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = 32'd1;
    sq_start  = 1'b0;
    sq_in     = '0;
    case (state_r)
      S_P_SQX: begin mul_a = mag32(dx_r); mul_b = mag32(dx_r); end
      S_P_SQY: begin mul_a = mag32(dy_r); mul_b = mag32(dy_r); end
      S_P_SQZ: begin mul_a = mag32(dz_r); mul_b = mag32(dz_r); end
      S_P_SUM: begin
        mul_a    = feed_r;
        mul_b    = scale_r;
        sq_start = 1'b1;
        sq_in    = acc_r + prod_r;
      end
      S_P_RTW: begin mul_a = feed_r; mul_b = scale_r; end
      S_P_DIV: begin
        div_start = 1'b1;
        case (dsel_r)
          2'd0:    div_dvd = {2'b00, mag32(rd_dx_r), 30'd0};
          2'd1:    div_dvd = {2'b00, mag32(rd_dy_r), 30'd0};
          2'd2:    div_dvd = {2'b00, mag32(dx_r), 30'd0};
          default: div_dvd = {2'b00, mag32(dy_r), 30'd0};
        endcase
        div_dsr = dsel_r[1] ? len_new_r : rd_len_r;
      end
      S_P_JX:   begin mul_a = exm; mul_b = exm; end
      S_P_JY:   begin mul_a = eym; mul_b = eym; end
      S_P_JS:   begin sq_start = 1'b1; sq_in = acc_r + prod_r; end
      S_P_POW:  begin mul_a = {1'b0, p_r}; mul_b = {1'b0, f_r}; end
      S_P_MEAN: begin mul_a = mean; mul_b = {1'b0, p_r}; end
      S_T_IM:   begin mul_a = dmag; mul_b = travel_r; end
      S_T_ID:   begin div_start = 1'b1; div_dvd = prod_r; div_dsr = rd_len_r; end
      S_C_MA:   begin mul_a = ck_lo; mul_b = ck_d; end
      S_C_MB:   begin mul_a = ck_d; mul_b = ck_d; end
      S_C_DIV:  begin
        div_start = 1'b1;
        div_dvd   = acc_r + (prod_r >> 1);
        div_dsr   = accel_eff;
      end
      default:  mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a * mul_b);
  end

  // queue memory
  assign ent_we  = (state_r == S_P_RTW) && sq_done && (sq_root != 32'd0) && !full;
  assign ex_we   = ent_we || (state_r == S_P_EXW);
  assign ex_addr = ent_we ? wp_r : rd_addr_r;
  assign ex_data = ent_we ? 32'd0 : prod_r[61:30];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      q_dx_mem[wp_r]   <= dx_r;
      q_dy_mem[wp_r]   <= dy_r;
      q_dz_mem[wp_r]   <= dz_r;
      q_len_mem[wp_r]  <= sq_root;
      q_base_mem[wp_r] <= prod_r[63:32];
    end
    if (ex_we) q_exit_mem[ex_addr] <= ex_data;
    rd_dx_r   <= q_dx_mem[rd_addr_r];
    rd_dy_r   <= q_dy_mem[rd_addr_r];
    rd_dz_r   <= q_dz_mem[rd_addr_r];
    rd_len_r  <= q_len_mem[rd_addr_r];
    rd_base_r <= q_base_mem[rd_addr_r];
    rd_exit_r <= q_exit_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ent_we) q_vld_r[wp_r] <= 1'b1;
      rd_vld_r <= q_vld_r[rd_addr_r];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      slot_r      <= '0;
      rd_addr_r   <= '0;
      active_r    <= 1'b0;
      exit_r      <= 1'b0;
      ck_ret_r    <= 1'b0;
      isel_r      <= 1'b0;
      dsel_r      <= '0;
      pcnt_r      <= '0;
      travel_r    <= '0;
      speed_r     <= '0;
      target_r    <= '0;
      ckpt_r      <= '0;
      tool_x_r    <= '0;
      tool_y_r    <= '0;
      tool_z_r    <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dx_r     <= in_delta_x;
            dy_r     <= in_delta_y;
            dz_r     <= in_delta_z;
            feed_r   <= in_feed;
            px_r     <= tool_x_r;
            py_r     <= tool_y_r;
            status_r <= ST_OK;
            isel_r   <= 1'b0;
            if (in_operation == OP_PUSH) begin
              rd_addr_r <= prev_ptr;
              state_r   <= S_P_SQX;
            end else begin
              rd_addr_r <= slot_r;
              state_r   <= S_T_RD;
            end
          end
        end
        S_P_SQX: state_r <= S_P_SQY;
        S_P_SQY: begin acc_r <= prod_r; state_r <= S_P_SQZ; end
        S_P_SQZ: begin acc_r <= acc_r + prod_r; state_r <= S_P_SUM; end
        S_P_SUM: state_r <= S_P_RTW;
        S_P_RTW: begin
          if (sq_done) begin
            len_new_r  <= sq_root;
            base_new_r <= prod_r[63:32];
            if (sq_root == 32'd0) begin
              status_r <= ST_ZERO;
              state_r  <= S_FIN;
            end else if (full) begin
              status_r <= ST_FULL;
              state_r  <= S_FIN;
            end else if (!rd_vld_r) begin
              wp_r    <= wp_r + 1'b1;
              state_r <= S_FIN;
            end else begin
              dsel_r  <= '0;
              state_r <= S_P_DIV;
            end
          end
        end
        S_P_DIV: state_r <= S_P_DIVW;
        S_P_DIVW: begin
          if (div_done) begin
            case (dsel_r)
              2'd0:    uxp_r <= rd_dx_r[31] ? (32'd0 - off) : off;
              2'd1:    uyp_r <= rd_dy_r[31] ? (32'd0 - off) : off;
              2'd2:    uxn_r <= dx_r[31] ? (32'd0 - off) : off;
              default: uyn_r <= dy_r[31] ? (32'd0 - off) : off;
            endcase
            dsel_r  <= dsel_r + 2'd1;
            state_r <= (dsel_r == 2'd3) ? S_P_JX : S_P_DIV;
          end
        end
        S_P_JX: state_r <= S_P_JY;
        S_P_JY: begin acc_r <= prod_r; state_r <= S_P_JS; end
        S_P_JS: state_r <= S_P_JSW;
        S_P_JSW: begin
          if (sq_done) begin
            f_r     <= ({1'b0, sq_root[31:1]} > {1'b0, ONE_Q30})
                       ? 31'd0 : 31'(ONE_Q30 - sq_root[31:1]);
            p_r     <= ONE_Q30;
            pcnt_r  <= '0;
            state_r <= S_P_POW;
          end
        end
        S_P_POW:  state_r <= (pcnt_r == jexp_r) ? S_P_MEAN : S_P_POW2;
        S_P_POW2: begin
          p_r     <= prod_r[60:30];
          pcnt_r  <= pcnt_r + 4'd1;
          state_r <= S_P_POW;
        end
        S_P_MEAN: state_r <= S_P_EXW;
        S_P_EXW: begin
          wp_r    <= wp_r + 1'b1;
          state_r <= S_FIN;
        end
        S_T_RD: state_r <= active_r ? S_T_IM : S_T_POP;
        S_T_IM: state_r <= S_T_ID;
        S_T_ID: state_r <= S_T_IW;
        S_T_IW: begin
          if (div_done) begin
            if (isel_r) begin
              py_r    <= sat34(ipos);
              state_r <= S_T_MAIN;
            end else begin
              px_r    <= sat34(ipos);
              isel_r  <= 1'b1;
              state_r <= S_T_IM;
            end
          end
        end
        S_T_MAIN: begin
          if (travel_r >= rd_len_r) begin
            tool_x_r <= sat34({{2{tool_x_r[31]}}, tool_x_r} + {{2{rd_dx_r[31]}}, rd_dx_r});
            tool_y_r <= sat34({{2{tool_y_r[31]}}, tool_y_r} + {{2{rd_dy_r[31]}}, rd_dy_r});
            tool_z_r <= sat34({{2{tool_z_r[31]}}, tool_z_r} + {{2{rd_dz_r[31]}}, rd_dz_r});
            active_r <= 1'b0;
            travel_r <= '0;
            exit_r   <= 1'b0;
            ckpt_r   <= '0;
            state_r  <= S_T_POP;
          end else begin
            exit_r   <= exit_r || trig;
            target_r <= tgt;
            if (ramp_diff <= accel_r) begin
              speed_r <= tgt;
              state_r <= S_T_FLR;
            end else begin
              speed_r <= (tgt < speed_r) ? (speed_r - accel_r) : (speed_r + accel_r);
              if (!(exit_r || trig)) begin
                ck_ret_r <= 1'b0;
                state_r  <= S_C_MA;
              end else begin
                state_r <= S_T_FLR;
              end
            end
          end
        end
        S_T_FLR: begin
          speed_r  <= sp_fl;
          travel_r <= (trav_sum > {1'b0, rd_len_r}) ? rd_len_r : trav_sum[31:0];
          state_r  <= S_T_POP;
        end
        S_T_POP: begin
          if (!active_r && (wp_r != rp_r)) begin
            slot_r    <= rp_r;
            active_r  <= 1'b1;
            rp_r      <= rp_r + 1'b1;
            rd_addr_r <= rp_r;
            state_r   <= S_T_PRD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_T_PRD: state_r <= S_T_PRD2;
        S_T_PRD2: begin
          target_r <= rd_base_r;
          ck_ret_r <= 1'b1;
          state_r  <= S_C_MA;
        end
        S_C_MA: state_r <= S_C_MB;
        S_C_MB: begin acc_r <= prod_r; state_r <= S_C_DIV; end
        S_C_DIV: state_r <= S_C_DIVW;
        S_C_DIVW: begin
          if (div_done) begin
            ckpt_r  <= (div_q < {32'd0, rd_len_r}) ? (rd_len_r - div_q[31:0]) : 32'd0;
            state_r <= ck_ret_r ? S_FIN : S_T_FLR;
          end
        end
        S_FIN: begin
          o_status_r  <= status_r;
          o_px_r      <= px_r;
          o_py_r      <= py_r;
          o_pz_r      <= tool_z_r;
          o_speed_r   <= speed_r;
          o_moving_r  <= active_r;
          o_count_r   <= wp_r - rp_r;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_pos_x       = o_px_r;
  assign out_pos_y       = o_py_r;
  assign out_pos_z       = o_pz_r;
  assign out_speed       = o_speed_r;
  assign out_moving      = o_moving_r;
  assign out_queue_count = o_count_r;

`ifndef ASSERT_OFF
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("request taken while result pending");
  a_exit_active: assert property (@(posedge clk) disable iff (!rst_n)
    exit_r |-> active_r) else $error("exit mode without active move");
  a_idle_travel: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (travel_r == 32'd0)) else $error("travel left over while idle");
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second request overlapped");
`endif

endmodule
